// ===== design/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DIV_STAGES = WORD_W;
  localparam int unsigned SIDE_W     = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  // Calibration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;

  localparam logic [31:0] B6_OFFSET    = 32'd4000;
  localparam logic [31:0] B7_SCALE     = 32'd50000;
  localparam logic [31:0] SIGN32       = 32'h8000_0000;
  localparam logic [31:0] P_SQ_COEF    = 32'd3038;
  localparam logic [31:0] P_LIN_COEF   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_OFFSET     = 32'd3791;
  localparam logic [31:0] B4_BIAS      = 32'd32768;
  localparam logic [17:0] PRESSURE_MAX = 18'h3FFFF;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    asr32 = $unsigned($signed(x) >>> n);
  endfunction

endpackage

// ===== design/bpc_if.sv =====
`timescale 1ns / 1ps

interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [15:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic [17:0]        pressure_pa;
  logic               divide_error;

  modport source (output valid, temperature_tenths, pressure_pa, divide_error,
                  input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, divide_error,
                output ready);
endinterface

// ===== design/bpc_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, side data rides along.
module bpc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [31:0]                num,
  input  logic [31:0]                den,
  input  logic [bpc_pkg::SIDE_W-1:0] side,
  output logic                       out_valid,
  output logic [31:0]                quo,
  output logic [bpc_pkg::SIDE_W-1:0] out_side
);

  localparam int unsigned N = bpc_pkg::DIV_STAGES;

  logic                       vld [N];
  logic [31:0]                rem [N];
  logic [31:0]                nq  [N];
  logic [31:0]                dv  [N];
  logic [bpc_pkg::SIDE_W-1:0] sd  [N];

  // One step: shift in the next numerator bit, subtract when it fits.
  function automatic logic [63:0] step(input logic [31:0] r, input logic [31:0] q,
                                       input logic [31:0] d);
    logic [32:0] t;
    logic        b;
    t = {r, q[31]};
    b = (t >= {1'b0, d});
    if (b) begin
      t = t - {1'b0, d};
    end
    step = {t[31:0], q[30:0], b};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rem[0], nq[0]} <= step(32'd0, num, den);
      dv[0] <= den;
      sd[0] <= side;
      for (int k = 1; k < N; k++) begin
        {rem[k], nq[k]} <= step(rem[k-1], nq[k-1], dv[k-1]);
        dv[k] <= dv[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = nq[N-1];
  assign out_side  = sd[N-1];

endmodule

// ===== design/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps

// Barometric pressure compensation.
// Each request on the sample channel carries one raw temperature word and one raw
// pressure word (oversampling zero). The block answers each request with exactly one
// result on the result channel: temperature in tenths of a degree, pressure in
// pascals, and a flag that is set when a divisor was zero (the values are then zero).
// Calibration coefficients are written through the cfg port; the user must do so
// only while no request is in flight, as the block itself does not enforce this.
// They reset to zero. From accepted request to result valid the data passes eleven
// arithmetic stages and two 32-stage pipelined dividers, one for the temperature
// quotient and one for the pressure quotient. A new request is taken in every cycle
// unless the pipeline is frozen. The whole pipeline advances together. While the
// result register holds an untaken result, the pipeline freezes and sample ready
// drops; nothing is lost or repeated. Synchronous reset clears all valid bits and the calibration registers.
module barometric_pressure_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  bpc_sample_if.sink                      sample,
  bpc_result_if.source                    result
);

  // Calibration registers.
  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpc_pkg::REG_AC1_AC2: cal_ac1_ac2 <= cfg_data;
        bpc_pkg::REG_AC3_AC4: cal_ac3_ac4 <= cfg_data;
        bpc_pkg::REG_AC5_AC6: cal_ac5_ac6 <= cfg_data;
        bpc_pkg::REG_B1_B2:   cal_b1_b2   <= cfg_data;
        bpc_pkg::REG_MC_MD:   cal_mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficients, widened to 32 bits.
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sext16(cal_ac1_ac2[31:16]);
  assign ac2 = bpc_pkg::sext16(cal_ac1_ac2[15:0]);
  assign ac3 = bpc_pkg::sext16(cal_ac3_ac4[31:16]);
  assign ac4 = {16'd0, cal_ac3_ac4[15:0]};
  assign ac5 = {16'd0, cal_ac5_ac6[31:16]};
  assign ac6 = {16'd0, cal_ac5_ac6[15:0]};
  assign b1  = bpc_pkg::sext16(cal_b1_b2[31:16]);
  assign b2  = bpc_pkg::sext16(cal_b1_b2[15:0]);
  assign mc  = bpc_pkg::sext16(cal_mc_md[31:16]);
  assign md  = bpc_pkg::sext16(cal_mc_md[15:0]);

  // The pipeline moves when the result register is empty or being taken.
  logic en;
  assign en = !result.valid || result.ready;
  assign sample.ready = en;

  // Stage A: (UT - AC6) * AC5.
  logic        a_v;
  logic [31:0] a_prod;
  logic [15:0] a_up;

  // Stage B: X1, the divisor and the signed operands as magnitudes.
  logic        b_v, b_neg, b_err;
  logic [31:0] b_x1, b_mnum, b_mden;
  logic [15:0] b_up;
  logic [31:0] b_x1_c, b_den_c, b_num_c;

  assign b_x1_c  = bpc_pkg::asr32(a_prod, 5'd15);
  assign b_den_c = b_x1_c + md;
  assign b_num_c = mc << 11;

  // Temperature divider.
  logic                       t_v;
  logic [31:0]                t_quo;
  logic [bpc_pkg::SIDE_W-1:0] t_side, t_side_out;
  assign t_side = {14'd0, b_x1, b_up, b_neg, b_err};

  // Stage C: B5.
  logic        c_v, c_err;
  logic [31:0] c_b5;
  logic [15:0] c_up;
  logic [31:0] c_q;
  assign c_q = t_side_out[1] ? (32'd0 - t_quo) : t_quo;

  // Stage D: B6, B6 squared, saturated temperature.
  logic        d_v, d_err;
  logic [31:0] d_b6, d_sq;
  logic [15:0] d_t, d_up;
  logic [31:0] d_b6_c, d_t_c;
  assign d_b6_c = c_b5 - bpc_pkg::B6_OFFSET;
  assign d_t_c  = bpc_pkg::asr32(c_b5 + 32'd8, 5'd4);

  // Stage E: the four coefficient products.
  logic        e_v, e_err;
  logic [31:0] e_p1, e_p2, e_p3, e_p4;
  logic [15:0] e_t, e_up;
  logic [31:0] e_b6sq;
  assign e_b6sq = bpc_pkg::asr32(d_sq, 5'd12);

  // Stage F: B3 and the biased X3.
  logic        f_v, f_err;
  logic [31:0] f_b3, f_x3b;
  logic [15:0] f_t, f_up;
  logic [31:0] f_x3a, f_x3c;
  assign f_x3a = bpc_pkg::asr32(e_p1, 5'd11) + bpc_pkg::asr32(e_p2, 5'd11);
  assign f_x3c = bpc_pkg::asr32(bpc_pkg::asr32(e_p3, 5'd13)
                 + bpc_pkg::asr32(e_p4, 5'd16) + 32'd2, 5'd2);

  // Stage G: B4 product and B7.
  logic        g_v, g_err;
  logic [31:0] g_b4p, g_b7;
  logic [15:0] g_t;

  // Stage H: B4, the unsigned numerator and the zero check.
  logic        h_v, h_err, h_sh;
  logic [31:0] h_num, h_b4;
  logic [15:0] h_t;
  logic [31:0] h_b4_c;
  assign h_b4_c = g_b4p >> 15;

  // Pressure divider.
  logic                       p_v;
  logic [31:0]                p_quo;
  logic [bpc_pkg::SIDE_W-1:0] p_side, p_side_out;
  assign p_side = {46'd0, h_t, h_err, h_sh};

  // Stage I: P and its two correction products.
  logic        i_v, i_err;
  logic [31:0] i_p, i_sqr, i_lin;
  logic [15:0] i_t;
  logic [31:0] i_p_c, i_p8;
  assign i_p_c = p_side_out[0] ? (p_quo << 1) : p_quo;
  assign i_p8  = bpc_pkg::asr32(i_p_c, 5'd8);

  // Stage J: the squared term times its coefficient.
  logic        j_v, j_err;
  logic [31:0] j_p, j_m1, j_x2;
  logic [15:0] j_t;

  // Stage K: the result register.
  logic [31:0] k_p_c;
  assign k_p_c = j_p + bpc_pkg::asr32(bpc_pkg::asr32(j_m1, 5'd16) + j_x2
                 + bpc_pkg::P_OFFSET, 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      a_v <= sample.valid;
      b_v <= a_v;
      c_v <= t_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= p_v;
      j_v <= i_v;
      result.valid <= j_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= ({16'd0, sample.raw_temperature} - ac6) * ac5;
      a_up   <= sample.raw_pressure;

      b_x1   <= b_x1_c;
      b_up   <= a_up;
      b_err  <= (b_den_c == 32'd0);
      b_neg  <= b_num_c[31] ^ b_den_c[31];
      b_mnum <= b_num_c[31] ? (32'd0 - b_num_c) : b_num_c;
      b_mden <= b_den_c[31] ? (32'd0 - b_den_c) : b_den_c;

      c_b5  <= t_side_out[49:18] + c_q;
      c_up  <= t_side_out[17:2];
      c_err <= t_side_out[0];

      d_b6  <= d_b6_c;
      d_sq  <= d_b6_c * d_b6_c;
      d_up  <= c_up;
      d_err <= c_err;
      if ($signed(d_t_c) > 32'sd32767) begin
        d_t <= 16'h7FFF;
      end else if ($signed(d_t_c) < -32'sd32768) begin
        d_t <= 16'h8000;
      end else begin
        d_t <= d_t_c[15:0];
      end

      e_p1  <= b2 * e_b6sq;
      e_p2  <= ac2 * d_b6;
      e_p3  <= ac3 * d_b6;
      e_p4  <= b1 * e_b6sq;
      e_t   <= d_t;
      e_up  <= d_up;
      e_err <= d_err;

      f_b3  <= bpc_pkg::asr32((ac1 << 2) + f_x3a + 32'd2, 5'd2);
      f_x3b <= f_x3c + bpc_pkg::B4_BIAS;
      f_t   <= e_t;
      f_up  <= e_up;
      f_err <= e_err;

      g_b4p <= ac4 * f_x3b;
      g_b7  <= ({16'd0, f_up} - f_b3) * bpc_pkg::B7_SCALE;
      g_t   <= f_t;
      g_err <= f_err;

      // Small B7 is doubled before the divide, large B7 after it.
      h_b4  <= h_b4_c;
      h_sh  <= (g_b7 >= bpc_pkg::SIGN32);
      h_num <= (g_b7 >= bpc_pkg::SIGN32) ? g_b7 : (g_b7 << 1);
      h_err <= g_err || (h_b4_c == 32'd0);
      h_t   <= g_t;

      i_p   <= i_p_c;
      i_sqr <= i_p8 * i_p8;
      i_lin <= bpc_pkg::P_LIN_COEF * i_p_c;
      i_t   <= p_side_out[17:2];
      i_err <= p_side_out[1];

      j_p   <= i_p;
      j_m1  <= i_sqr * bpc_pkg::P_SQ_COEF;
      j_x2  <= bpc_pkg::asr32(i_lin, 5'd16);
      j_t   <= i_t;
      j_err <= i_err;

      result.divide_error <= j_err;
      if (j_err) begin
        result.temperature_tenths <= '0;
        result.pressure_pa        <= '0;
      end else begin
        result.temperature_tenths <= j_t;
        if (k_p_c[31]) begin
          result.pressure_pa <= '0;
        end else if (k_p_c > {14'd0, bpc_pkg::PRESSURE_MAX}) begin
          result.pressure_pa <= bpc_pkg::PRESSURE_MAX;
        end else begin
          result.pressure_pa <= k_p_c[17:0];
        end
      end
    end
  end

  bpc_div u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .num       (b_mnum),
    .den       (b_mden),
    .side      (t_side),
    .out_valid (t_v),
    .quo       (t_quo),
    .out_side  (t_side_out)
  );

  bpc_div u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_v),
    .num       (h_num),
    .den       (h_b4),
    .side      (p_side),
    .out_valid (p_v),
    .quo       (p_quo),
    .out_side  (p_side_out)
  );

endmodule

// ===== sim/tb_barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps

// Scoreboard for the pressure compensation block. It recomputes each accepted
// request with its own copy of the calibration and holds the expected results
// in arrival order.
class compensation_scoreboard;
  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_error;
  } reading_t;

  logic [31:0] cal [5];
  reading_t    pending_readings[$];
  int          error_count;

  function new();
    foreach (cal[i]) cal[i] = '0;
    error_count = 0;
  endfunction

  function void write_cal(logic [2:0] idx, logic [31:0] value);
    if (idx <= bpc_pkg::REG_MC_MD) cal[idx] = value;
  endfunction

  // Arithmetic shift right of a 32-bit pattern.
  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_w, logic [15:0] up_w);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, t, b6, b6sq, b3, b4, b7, p;
    reading_t r;
    ac1 = sx(cal[bpc_pkg::REG_AC1_AC2][31:16]);
    ac2 = sx(cal[bpc_pkg::REG_AC1_AC2][15:0]);
    ac3 = sx(cal[bpc_pkg::REG_AC3_AC4][31:16]);
    ac4 = {16'd0, cal[bpc_pkg::REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal[bpc_pkg::REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal[bpc_pkg::REG_AC5_AC6][15:0]};
    b1 = sx(cal[bpc_pkg::REG_B1_B2][31:16]);
    b2 = sx(cal[bpc_pkg::REG_B1_B2][15:0]);
    mc = sx(cal[bpc_pkg::REG_MC_MD][31:16]);
    md = sx(cal[bpc_pkg::REG_MC_MD][15:0]);
    r = '0;
    x1 = sra(({16'd0, ut_w} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t = sra(b5 + 32'd8, 4);
    b6 = b5 - bpc_pkg::B6_OFFSET;
    b6sq = sra(b6 * b6, 12);
    x1 = sra(b2 * b6sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(ac1 * 32'd4 + x3 + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * b6sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::B4_BIAS)) >> 15;
    if (b4 == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    b7 = ({16'd0, up_w} - b3) * bpc_pkg::B7_SCALE;
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * bpc_pkg::P_SQ_COEF, 16);
    x2 = sra(bpc_pkg::P_LIN_COEF * p, 16);
    p = p + sra(x1 + x2 + bpc_pkg::P_OFFSET, 4);
    if ($signed(t) > 32767) r.temperature_tenths = 16'sh7FFF;
    else if ($signed(t) < -32768) r.temperature_tenths = 16'sh8000;
    else r.temperature_tenths = t[15:0];
    if (p[31]) r.pressure_pa = '0;
    else if (p > 32'd262143) r.pressure_pa = bpc_pkg::PRESSURE_MAX;
    else r.pressure_pa = p[17:0];
    return r;
  endfunction

  function void note_sample(logic [15:0] ut_w, logic [15:0] up_w);
    pending_readings.insert(pending_readings.size(), compensate(ut_w, up_w));
  endfunction

  function void check_reading(logic signed [15:0] tt, logic [17:0] pp, logic de);
    reading_t e;
    if (pending_readings.size() == 0) begin
      $error("unexpected result: temperature %0d pressure %0d error %0b", tt, pp, de);
      error_count++;
      return;
    end
    e = pending_readings.pop_front();
    if (tt !== e.temperature_tenths) begin
      $error("temperature_tenths: expected %0d, actual %0d", e.temperature_tenths, tt);
      error_count++;
    end
    if (pp !== e.pressure_pa) begin
      $error("pressure_pa: expected %0d, actual %0d", e.pressure_pa, pp);
      error_count++;
    end
    if (de !== e.divide_error) begin
      $error("divide_error: expected %0b, actual %0b", e.divide_error, de);
      error_count++;
    end
  endfunction
endclass

module tb_barometric_pressure_compensation;

  // Idle cycles the drain waits after the last expected result has come.
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  // When set, neither side idles; used for a long stretch of back-to-back traffic.
  logic        steady;

  bpc_sample_if sample ();
  bpc_result_if result ();

  barometric_pressure_compensation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample.sink),
    .result    (result.source)
  );

  compensation_scoreboard readings = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. The slowest correct run is about 1500 requests plus drains between
  // phases; this gives a wide margin.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: ready drops about 9 times in a hundred, except in steady runs.
  // Every accepted result is handed to the scoreboard at the edge it is taken.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready)
        readings.check_reading(result.temperature_tenths, result.pressure_pa,
                               result.divide_error);
      result.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Drives one calibration register write, one cycle long, then leaves write low before returning.
  task automatic write_cal(logic [2:0] idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    readings.write_cal(idx, value);
    @(posedge clk);
  endtask

  task automatic load_calibration(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                  logic [31:0] c3, logic [31:0] c4);
    write_cal(bpc_pkg::REG_AC1_AC2, c0);
    write_cal(bpc_pkg::REG_AC3_AC4, c1);
    write_cal(bpc_pkg::REG_AC5_AC6, c2);
    write_cal(bpc_pkg::REG_B1_B2, c3);
    write_cal(bpc_pkg::REG_MC_MD, c4);
  endtask

  // Sends one request, holding valid until it is taken. Random idle cycles go
  // before the request, so valid is never dropped and raised in the same step.
  task automatic send_sample(logic [15:0] ut_w, logic [15:0] up_w);
    while (!steady && $urandom_range(99) < 9) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid           <= 1'b1;
    sample.raw_temperature <= ut_w;
    sample.raw_pressure    <= up_w;
    do @(posedge clk); while (!sample.ready);
    readings.note_sample(ut_w, up_w);
  endtask

  // Lowers valid and waits until every expected result has come, then lets the
  // pipeline settle so calibration can be changed safely.
  task automatic drain;
    int spare;
    sample.valid <= 1'b0;
    @(posedge clk);
    while (readings.pending_readings.size() != 0) @(posedge clk);
    spare = 0;
    while (spare < DRAIN_CYCLES) begin
      @(posedge clk);
      spare++;
    end
  endtask

  // A random calibration: mostly near typical sensor values, sometimes anything.
  task automatic random_calibration;
    if ($urandom_range(3) == 0) begin
      load_calibration($urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      load_calibration(
        {16'(408 + $urandom_range(200) - 100), 16'(-72 + $urandom_range(100) - 50)},
        {16'(-14383 + $urandom_range(2000) - 1000), 16'(32741 + $urandom_range(2000) - 1000)},
        {16'(32757 + $urandom_range(2000) - 1000), 16'(23153 + $urandom_range(2000) - 1000)},
        {16'(6190 + $urandom_range(400) - 200), 16'(4 + $urandom_range(8))},
        {16'(-8711 + $urandom_range(400) - 200), 16'(2868 + $urandom_range(400) - 200)});
    end
  endtask

  initial begin
    int phase;
    int n;
    sample.valid           = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure    = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    rst       = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With all coefficients zero, X1 + MD is zero, so the temperature divisor fault
    // shows at once.
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    drain();

    // Datasheet example calibration, with field extremes and typical readings.
    load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                     {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    send_sample(16'd27898, 16'd23843);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    // Unused index writes are ignored.
    drain();
    write_cal(3'd7, 32'hFFFF_FFFF);
    write_cal(3'd5, 32'h1234_5678);
    send_sample(16'd27898, 16'd23843);
    drain();

    // AC4 of zero makes B4 zero: the pressure divisor fault.
    write_cal(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd0});
    send_sample(16'd27898, 16'd23843);
    send_sample(16'd1000, 16'd40000);
    drain();

    // MC at its most negative with MD of minus one and no X1 term: the temperature
    // quotient takes its largest magnitude.
    load_calibration(32'h7FFF_8000, 32'h8000_FFFF, 32'h0000_FFFF, 32'h7FFF_8000,
                     32'h8000_FFFF);
    send_sample(16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd12345);
    drain();

    // All-ones and extreme calibration to push saturation both ways.
    load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h8000, 16'h7FFF);
    drain();
    load_calibration(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF,
                     32'h7FFF_0001);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    drain();

    // Random phases, each with its own calibration. One phase runs without idling.
    for (phase = 0; phase < 14; phase++) begin
      random_calibration();
      steady = (phase == 6);
      for (n = 0; n < 100; n++) begin
        if ($urandom_range(4) == 0)
          send_sample($urandom, $urandom);
        else
          send_sample(16'(27898 + $urandom_range(16000) - 8000),
                      16'(23843 + $urandom_range(16000) - 8000));
      end
      steady = 1'b0;
      drain();
    end

    if (readings.error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
